// ----- hdl/command_line_framer_top_assert.svh -----
// Assertion macros shared by the line framer modules.
// Needs clk and arst_n in the scope of use.
`ifndef COMMAND_LINE_FRAMER_TOP_ASSERT_SVH
`define COMMAND_LINE_FRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define CLF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clf assertion failed");

// next-cycle implication
`define CLF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clf assertion failed");

`endif

// ----- hdl/clf_pkg.sv -----
// Types and constants of the command line framer.
// No dependencies.
package clf_pkg;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic KIND_CMD = 1'b0;
	localparam logic KIND_ERR = 1'b1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_COUNT    = 3'd1;
	localparam logic [2:0] ST_NO_COLON = 3'd2;
	localparam logic [2:0] ST_BAD_CHAR = 3'd3;
	localparam logic [2:0] ST_NO_CR    = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PW    = 2;
	localparam int OQ_CW    = 3;

	typedef struct packed {
		logic       kind;
		logic [7:0] cmd_byte;
		logic [2:0] status;
		logic       last;
	} clf_result_t;

	typedef struct packed {
		logic        valid;
		clf_result_t item;
	} clf_push_t;

	typedef struct packed {
		logic [OQ_CW-1:0] count;
	} clf_oq_stat_t;

endpackage

// ----- hdl/clf_ifs.sv -----
// Handshake channels of the command line framer: received bytes,
// configuration writes and results. No dependencies.
interface clf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface clf_cfg_if;
	logic valid;
	logic ready;
	logic drop_nul;
	modport source (output valid, output drop_nul, input ready);
	modport sink (input valid, input drop_nul, output ready);
endinterface

interface clf_result_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] cmd_byte;
	logic [2:0] status;
	logic       last;
	modport source (output valid, output kind, output cmd_byte, output status,
		output last, input ready);
	modport sink (input valid, input kind, input cmd_byte, input status,
		input last, output ready);
endinterface

// ----- hdl/command_line_framer_top.sv -----
// Channel     Dir  Payload
// rx          in   rx_byte[7:0]
// cfg         in   drop_nul
// res         out  kind, cmd_byte[7:0], status[2:0], last
//
// A stored, dropped or error-answered byte is handled when it is accepted.
// A valid line of n bytes streams n-1 results from the line buffer, one per
// cycle while the queue has room, after the buffer's registered read; rx is
// held off until the last read has landed in the four-entry result queue.
// Reset clears control state only; the line buffer is not cleared.
// Stalls on res back up through the queue to the buffer read and to rx.
// Top level of the command line framer. Depends on clf_pkg, clf_ifs,
// clf_ctrl, clf_line_mem and clf_out_queue.
module command_line_framer_top
	import clf_pkg::*;
#(
	parameter int BUF_SIZE = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	clf_byte_if.sink     rx,
	clf_cfg_if.sink      cfg,
	clf_result_if.source res
);

	localparam int AW = $clog2(BUF_SIZE);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	clf_push_t     push;
	clf_oq_stat_t  oq_stat;

	clf_ctrl #(
		.BUF_SIZE (BUF_SIZE),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg       (cfg),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.push      (push),
		.oq_stat   (oq_stat)
	);

	clf_line_mem #(
		.DEPTH (BUF_SIZE),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	clf_out_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.stat   (oq_stat),
		.res    (res)
	);

endmodule

// ----- hdl/clf_line_mem.sv -----
// Line buffer: one write port, one read port, registered read data.
// No dependencies.
module clf_line_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/clf_out_queue.sv -----
// Result queue in front of the output channel.
// Depends on clf_pkg and clf_ifs.
module clf_out_queue
	import clf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  clf_push_t          push,
	output clf_oq_stat_t       stat,
	clf_result_if.source       res
);

	clf_result_t      q_q [OQ_DEPTH];
	logic [OQ_PW-1:0] wr_ptr_q;
	logic [OQ_PW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] count_q;
	logic             pop;
	clf_result_t      head;

	assign head         = q_q[rd_ptr_q];
	assign res.valid    = (count_q != '0);
	assign res.kind     = head.kind;
	assign res.cmd_byte = head.cmd_byte;
	assign res.status   = head.status;
	assign res.last     = head.last;
	assign pop          = res.valid && res.ready;
	assign stat.count   = count_q;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			q_q[wr_ptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + OQ_PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PW'(1);
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + OQ_CW'(1);
				2'b01:   count_q <= count_q - OQ_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/clf_ctrl.sv -----
// Framer control: collects bytes into the line buffer, checks the line on
// a line feed and streams a valid line back out. Depends on clf_pkg, clf_ifs and
// the assertion macros.
`include "command_line_framer_top_assert.svh"

module clf_ctrl
	import clf_pkg::*;
#(
	parameter int BUF_SIZE = 64,
	parameter int AW       = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	clf_byte_if.sink      rx,
	clf_cfg_if.sink       cfg,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [7:0]    mem_rdata,
	output clf_push_t     push,
	input  clf_oq_stat_t  oq_stat
);

	typedef enum logic {COLLECT, READOUT} state_t;

	localparam logic [AW-1:0] FULL_N = AW'(BUF_SIZE - 1);

	state_t        state_q;
	logic [AW-1:0] fill_q;
	logic          drop_nul_q;
	logic [7:0]    b0_q;
	logic [7:0]    b1_q;
	logic [7:0]    tail_q;
	logic [AW-1:0] rd_idx_q;
	logic [AW-1:0] rd_end_q;
	logic          pend_s1;
	logic          last_s1;

	logic          acc;
	logic          err_v;
	logic [2:0]    err_st;
	logic          go_rd;
	logic          store;
	logic          clr;
	logic          issue;
	logic [OQ_CW:0] credit;

	assign credit    = {1'b0, oq_stat.count} + {{OQ_CW{1'b0}}, pend_s1};
	assign rx.ready  = (state_q == COLLECT) && !pend_s1 &&
		(oq_stat.count < OQ_CW'(OQ_DEPTH));
	assign cfg.ready = 1'b1;
	assign acc       = rx.valid && rx.ready;
	assign issue     = (state_q == READOUT) && (credit < (OQ_CW + 1)'(OQ_DEPTH));

	always_comb begin
		err_v  = 1'b0;
		err_st = ST_OK;
		go_rd  = 1'b0;
		store  = 1'b0;
		clr    = 1'b0;
		if (acc && !(rx.rx_byte == CH_NUL && drop_nul_q)) begin
			if (rx.rx_byte == CH_LF) begin
				clr = 1'b1;
				if (fill_q == AW'(2)) begin
					err_v = 1'b1;
					if (b0_q == CH_COLON && b1_q == CH_CR) begin
						err_st = ST_COUNT;
					end else if (b1_q == CH_CR) begin
						err_st = ST_NO_COLON;
					end else begin
						err_st = ST_BAD_CHAR;
					end
				end else if (fill_q >= AW'(3)) begin
					if (b1_q != CH_COLON) begin
						err_v  = 1'b1;
						err_st = ST_NO_COLON;
					end else if (tail_q == CH_CR) begin
						go_rd = 1'b1;
					end else begin
						err_v  = 1'b1;
						err_st = ST_NO_CR;
					end
				end
			end else if (fill_q < FULL_N) begin
				store = 1'b1;
			end else begin
				err_v  = 1'b1;
				err_st = ST_OVERFLOW;
				clr    = 1'b1;
			end
		end
	end

	always_comb begin
		push.valid = pend_s1 || err_v;
		if (pend_s1) begin
			push.item.kind     = KIND_CMD;
			push.item.cmd_byte = mem_rdata;
			push.item.status   = ST_OK;
			push.item.last     = last_s1;
		end else begin
			push.item.kind     = KIND_ERR;
			push.item.cmd_byte = 8'h00;
			push.item.status   = err_st;
			push.item.last     = 1'b1;
		end
	end

	assign mem_we    = store;
	assign mem_waddr = fill_q;
	assign mem_wdata = rx.rx_byte;
	assign mem_re    = issue;
	assign mem_raddr = rd_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= COLLECT;
			fill_q     <= '0;
			drop_nul_q <= 1'b1;
			b0_q       <= '0;
			b1_q       <= '0;
			tail_q     <= '0;
			rd_idx_q   <= '0;
			rd_end_q   <= '0;
			pend_s1    <= 1'b0;
			last_s1    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				drop_nul_q <= cfg.drop_nul;
			end
			if (store) begin
				fill_q <= fill_q + AW'(1);
				tail_q <= rx.rx_byte;
				if (fill_q == AW'(0)) begin
					b0_q <= rx.rx_byte;
				end
				if (fill_q == AW'(1)) begin
					b1_q <= rx.rx_byte;
				end
			end
			if (clr) begin
				fill_q <= '0;
			end
			pend_s1 <= issue;
			last_s1 <= (rd_idx_q == rd_end_q);
			unique case (state_q)
				COLLECT: begin
					if (go_rd) begin
						state_q  <= READOUT;
						rd_idx_q <= '0;
						rd_end_q <= fill_q - AW'(2);
					end
				end
				READOUT: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + AW'(1);
						if (rd_idx_q == rd_end_q) begin
							state_q <= COLLECT;
						end
					end
				end
				default: state_q <= COLLECT;
			endcase
		end
	end

	// queue never overrun
	`CLF_ASSERT_IMP(a_no_overrun, push.valid, oq_stat.count < OQ_CW'(OQ_DEPTH))
	// no input taken while a line read is still landing
	`CLF_ASSERT_IMP(a_no_acc_in_flight, acc, !pend_s1 && state_q == COLLECT)
	// fill stays below the buffer size
	`CLF_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FULL_N)
	// a read issue always lands as a push in the next cycle
	`CLF_ASSERT_NXT(a_read_lands, issue, push.valid && push.item.kind == KIND_CMD)

endmodule

// ----- bench/tb_command_line_framer_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for command_line_framer_top: drives received bytes, predicts
// framed command runs and error reports, and checks every result in order.
// Depends on clf_pkg, clf_ifs and the framer RTL.
module tb_command_line_framer_top;
	import clf_pkg::*;

	localparam int BUF_SIZE      = 64;
	localparam int SETTLE_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n;

	clf_byte_if   rx_ch ();
	clf_cfg_if    cfg_ch ();
	clf_result_if res_ch ();

	command_line_framer_top #(.BUF_SIZE(BUF_SIZE)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.cfg    (cfg_ch),
		.res    (res_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// framer state as the bench sees it
	logic [7:0]  line_buf [BUF_SIZE];
	int          line_fill;
	logic        nul_drop_q;
	clf_result_t pending_out [$];

	int fail_count;
	int sent_items;
	bit rx_gaps_on;
	bit res_stalls_on;
	int res_hold_cycles;

	function automatic void report_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	function automatic void compare_field(string field, int unsigned want, int unsigned got);
		if (want != got)
			report_failure($sformatf("%s expected 0x%0h, got 0x%0h", field, want, got));
	endfunction

	function automatic void push_result(logic kind, logic [7:0] cbyte, logic [2:0] status,
		logic last);
		clf_result_t r;
		r.kind     = kind;
		r.cmd_byte = cbyte;
		r.status   = status;
		r.last     = last;
		pending_out.push_back(r);
	endfunction

	function automatic void frame_byte(logic [7:0] b);
		if (b == CH_NUL && nul_drop_q)
			return;
		if (b == CH_LF) begin
			if (line_fill == 2) begin
				if (line_buf[0] == CH_COLON && line_buf[1] == CH_CR)
					push_result(KIND_ERR, 8'h00, ST_COUNT, 1'b1);
				else if (line_buf[0] != CH_COLON && line_buf[1] == CH_CR)
					push_result(KIND_ERR, 8'h00, ST_NO_COLON, 1'b1);
				else
					push_result(KIND_ERR, 8'h00, ST_BAD_CHAR, 1'b1);
			end else if (line_fill >= 3) begin
				if (line_buf[1] != CH_COLON) begin
					push_result(KIND_ERR, 8'h00, ST_NO_COLON, 1'b1);
				end else if (line_buf[line_fill-1] == CH_CR) begin
					for (int i = 0; i < line_fill - 1; i++)
						push_result(KIND_CMD, line_buf[i], ST_OK, (i == line_fill - 2));
				end else begin
					push_result(KIND_ERR, 8'h00, ST_NO_CR, 1'b1);
				end
			end
			line_fill = 0;
		end else if (line_fill < BUF_SIZE - 1) begin
			line_buf[line_fill] = b;
			line_fill++;
		end else begin
			push_result(KIND_ERR, 8'h00, ST_OVERFLOW, 1'b1);
			line_fill = 0;
		end
	endfunction

	// results are checked before the same edge's request is framed
	always @(posedge clk) begin
		clf_result_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_out.size() == 0) begin
					report_failure($sformatf("unexpected result kind=%0d byte=0x%0h status=%0d last=%0d",
						res_ch.kind, res_ch.cmd_byte, res_ch.status, res_ch.last));
				end else begin
					want = pending_out.pop_front();
					compare_field("kind", want.kind, res_ch.kind);
					compare_field("cmd_byte", want.cmd_byte, res_ch.cmd_byte);
					compare_field("status", want.status, res_ch.status);
					compare_field("last", want.last, res_ch.last);
				end
			end
			if (rx_ch.valid && rx_ch.ready)
				frame_byte(rx_ch.rx_byte);
			if (cfg_ch.valid && cfg_ch.ready)
				nul_drop_q = cfg_ch.drop_nul;
		end
	end

	// result receiver: random stalls, plus a long hold when requested
	initial begin
		int gap;
		res_ch.ready = 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (res_hold_cycles > 0) begin
				res_ch.ready <= 1'b0;
				repeat (res_hold_cycles) @(posedge clk);
				res_hold_cycles = 0;
			end else begin
				gap = res_stalls_on ? $urandom_range(0, 9) : 0;
				if (gap > 0) begin
					res_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = rx_gaps_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		sent_items++;
	endtask

	task automatic wait_idle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_out.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_drop_nul(input logic v);
		wait_idle();
		cfg_ch.valid    <= 1'b1;
		cfg_ch.drop_nul <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [7:0] rand_data();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CH_LF)
			b = CH_CR;
		return b;
	endfunction

	task automatic send_command(input int body_len);
		send_byte(rand_data());
		send_byte(CH_COLON);
		repeat (body_len) send_byte(rand_data());
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	task automatic test_nul_dropped_at_reset();
		send_byte(8'h41);
		send_byte(CH_NUL);
		send_byte(CH_COLON);
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	task automatic test_nul_kept();
		send_byte(CH_NUL);
		send_byte(CH_COLON);
		send_byte(8'hFF);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_NUL);
		send_byte(CH_NUL);
		send_byte(CH_LF);
	endtask

	task automatic test_short_lines();
		send_byte(CH_LF);
		send_byte(8'h61);
		send_byte(CH_LF);
	endtask

	task automatic test_framing_errors();
		send_byte(CH_COLON);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(8'h78);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_COLON);
		send_byte(8'h78);
		send_byte(CH_LF);
		send_byte(8'h51);
		send_byte(8'h51);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(8'h51);
		send_byte(CH_COLON);
		send_byte(8'h7A);
		send_byte(CH_LF);
	endtask

	task automatic test_valid_line();
		send_byte(8'h80);
		send_byte(CH_COLON);
		send_byte(8'hFF);
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	task automatic test_overflow();
		repeat (BUF_SIZE) send_byte(rand_data());
		send_byte(CH_LF);
		send_command(2);
	endtask

	task automatic test_longest_line();
		send_command(BUF_SIZE - 4);
	endtask

	task automatic test_backpressure();
		rx_gaps_on      = 1'b0;
		res_hold_cycles = 300;
		repeat (3) send_command(20);
		wait_idle();
	endtask

	task automatic send_random_line();
		int pick;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 7) == 0)
			rx_gaps_on = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 7) == 0)
			res_stalls_on = 1'($urandom_range(0, 1));
		if (pick < 70) begin
			send_command(($urandom_range(0, 15) == 0) ? $urandom_range(0, BUF_SIZE - 4)
				: $urandom_range(0, 6));
		end else if (pick < 82) begin
			repeat ($urandom_range(0, 5)) begin
				case ($urandom_range(0, 2))
					0: begin
						send_byte(CH_COLON);
					end
					1: begin
						send_byte(CH_CR);
					end
					default: begin
						send_byte(rand_data());
					end
				endcase
			end
			send_byte(CH_LF);
		end else if (pick < 86) begin
			repeat ($urandom_range(BUF_SIZE - 1, BUF_SIZE + 2)) send_byte(rand_data());
			send_byte(CH_LF);
		end else begin
			repeat ($urandom_range(1, 12))
				send_byte(($urandom_range(0, 3) == 0) ? CH_LF : 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_random_traffic(input int n_items);
		int start;
		start = sent_items;
		while (sent_items - start < n_items)
			send_random_line();
		rx_gaps_on    = 1'b1;
		res_stalls_on = 1'b1;
	endtask

	initial begin
		arst_n          = 1'b0;
		rx_ch.valid     = 1'b0;
		rx_ch.rx_byte   = 8'h00;
		cfg_ch.valid    = 1'b0;
		cfg_ch.drop_nul = 1'b1;
		line_fill       = 0;
		nul_drop_q      = 1'b1;
		fail_count      = 0;
		sent_items      = 0;
		rx_gaps_on      = 1'b0;
		res_stalls_on   = 1'b0;
		res_hold_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_nul_dropped_at_reset();
		rx_gaps_on    = 1'b1;
		res_stalls_on = 1'b1;
		set_drop_nul(1'b0);
		test_nul_kept();
		set_drop_nul(1'b1);
		test_short_lines();
		test_framing_errors();
		test_valid_line();
		test_overflow();
		test_longest_line();
		test_backpressure();
		rx_gaps_on = 1'b1;
		test_random_traffic(80);
		set_drop_nul(1'b0);
		test_random_traffic(80);
		set_drop_nul(1'b1);

		wait_idle();
		while (pending_out.size() != 0) begin
			void'(pending_out.pop_front());
			report_failure("expected result never arrived");
		end
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- command_line_framer_top.f -----
+incdir+hdl
hdl/clf_pkg.sv
hdl/clf_ifs.sv
hdl/clf_line_mem.sv
hdl/clf_out_queue.sv
hdl/clf_ctrl.sv
hdl/command_line_framer_top.sv
bench/tb_command_line_framer_top.sv
